// File: rtl/igrfa_pkg.sv
// Shared definitions for the idle-gap receive frame assembler.
// Holds the command and register codes, field widths and the result flag struct.
// No dependencies.
package igrfa_pkg;

    localparam int POOL_DEPTH_DEFAULT = 256;
    localparam int CMD_W              = 2;
    localparam int BYTE_W             = 8;
    localparam int STAMP_W            = 32;
    localparam int RIDX_W             = 8;
    localparam int TICK_W             = 8;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 32;

    localparam logic [TICK_W-1:0]  IDLE_TICKS_RESET = TICK_W'(2);
    localparam logic [TICK_W-1:0]  TICK_MAX         = {TICK_W{1'b1}};
    localparam logic [STAMP_W-1:0] GAP_LIMIT_RESET  = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_LIMIT  = 1'b0,
        CFG_IDLE_TICKS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic frame_ready;
        logic read_valid;
        logic byte_dropped;
    } res_flags_t;

endpackage

// File: rtl/igrfa_store.sv
// Frame byte store: one write port, one read port with registered read data.
// Depends on igrfa_pkg for the byte width.
module igrfa_store #(
    parameter int   POOL_DEPTH = igrfa_pkg::POOL_DEPTH_DEFAULT,
    localparam int  ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [igrfa_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [igrfa_pkg::BYTE_W-1:0] rd_data
);
    import igrfa_pkg::*;

    logic [BYTE_W-1:0] mem [POOL_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/igrfa_ctrl.sv
// Frame control: config registers, frame state and the per-beat update.
// Depends on igrfa_pkg; drives the write and read ports of igrfa_store.
module igrfa_ctrl #(
    parameter int  POOL_DEPTH = igrfa_pkg::POOL_DEPTH_DEFAULT,
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1),
    localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [igrfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [igrfa_pkg::CFG_DATA_W-1:0] cfg_data,
    // item in the input register, committed when item_en is high
    input  logic                             item_en,
    input  igrfa_pkg::cmd_t                  cmd,
    input  logic [igrfa_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [igrfa_pkg::STAMP_W-1:0]    stamp,
    input  logic [igrfa_pkg::RIDX_W-1:0]     read_index,
    // store ports
    output logic                             wr_en,
    output logic [ADDR_W-1:0]                wr_addr,
    output logic [igrfa_pkg::BYTE_W-1:0]     wr_data,
    output logic                             rd_en,
    output logic [ADDR_W-1:0]                rd_addr,
    // result of this beat
    output igrfa_pkg::res_flags_t            flags,
    output logic [CNT_W-1:0]                 count
);
    import igrfa_pkg::*;

    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    logic [STAMP_W-1:0] gap_limit_reg;
    logic [TICK_W-1:0]  idle_ticks_reg;

    logic [CNT_W-1:0]   count_reg,      count_next;
    logic               awaiting_reg,   awaiting_next;
    logic               closed_reg,     closed_next;
    logic [STAMP_W-1:0] last_stamp_reg, last_stamp_next;
    logic [TICK_W-1:0]  idle_reg,       idle_next;

    logic               full;
    logic               gap_over;
    logic [STAMP_W-1:0] gap;
    logic [TICK_W-1:0]  idle_inc;
    logic [CMP_W-1:0]   ridx_ext;
    logic               rd_hit;
    logic               take_byte;
    logic               dropped;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_limit_reg  <= GAP_LIMIT_RESET;
            idle_ticks_reg <= IDLE_TICKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_GAP_LIMIT:  gap_limit_reg  <= cfg_data[STAMP_W-1:0];
                CFG_IDLE_TICKS: idle_ticks_reg <= cfg_data[TICK_W-1:0];
                default:        ;
            endcase
        end
    end

    assign full     = (count_reg == CNT_W'(POOL_DEPTH));
    assign gap      = stamp - last_stamp_reg;   // modular difference
    assign gap_over = (gap > gap_limit_reg);
    assign idle_inc = (idle_reg == TICK_MAX) ? idle_reg : idle_reg + TICK_W'(1);
    assign ridx_ext = CMP_W'(read_index);
    assign rd_hit   = (ridx_ext < CMP_W'(count_reg));

    always_comb begin
        count_next      = count_reg;
        awaiting_next   = awaiting_reg;
        closed_next     = closed_reg;
        last_stamp_next = last_stamp_reg;
        idle_next       = idle_reg;
        take_byte       = 1'b0;
        dropped         = 1'b0;
        wr_en           = 1'b0;

        unique case (cmd)
            CMD_BYTE: begin
                if (awaiting_reg) begin
                    awaiting_next = 1'b0;
                    take_byte     = 1'b1;
                end else if (closed_reg) begin
                    dropped = 1'b1;
                end else if (gap_over) begin
                    closed_next = 1'b1;
                    dropped     = 1'b1;
                end else begin
                    take_byte = 1'b1;
                end
                if (take_byte) begin
                    last_stamp_next = stamp;
                    idle_next       = '0;
                    if (full) begin
                        dropped = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            CMD_TICK: begin
                if (!awaiting_reg && !closed_reg) begin
                    idle_next = idle_inc;
                    if (idle_inc >= idle_ticks_reg) begin
                        closed_next = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                count_next    = '0;
                closed_next   = 1'b0;
                awaiting_next = 1'b1;
                idle_next     = '0;
            end
            CMD_READ: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            awaiting_reg   <= 1'b1;
            closed_reg     <= 1'b0;
            last_stamp_reg <= '0;
            idle_reg       <= '0;
        end else if (item_en) begin
            count_reg      <= count_next;
            awaiting_reg   <= awaiting_next;
            closed_reg     <= closed_next;
            last_stamp_reg <= last_stamp_next;
            idle_reg       <= idle_next;
        end
    end

    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;

    assign rd_en   = (cmd == CMD_READ) && rd_hit;
    assign rd_addr = ridx_ext[ADDR_W-1:0];

    assign flags.frame_ready  = closed_next;
    assign flags.read_valid   = (cmd == CMD_READ) && rd_hit;
    assign flags.byte_dropped = (cmd == CMD_BYTE) && dropped;
    assign count              = count_next;

endmodule

// File: rtl/idle_gap_rx_frame_assembler.sv
// Top level of the idle-gap receive frame assembler.
// Depends on igrfa_pkg, igrfa_ctrl and igrfa_store.
//
// Collects received UART bytes into a frame and closes the frame on an idle
// gap: the timestamp gap between bytes exceeding gap_limit (config register 0,
// modulo 2^32), or idle_ticks tick beats (register 1) with no new byte. A byte
// after closing, or past a full buffer, is flagged dropped. A release beat
// reopens the frame; read beats return stored bytes by index at any time.
// Every input beat gives exactly one result beat. Throughput is one beat per
// clock while the result channel is not stalled by m_ready. The accepting
// edge loads the input register, and a later edge does the frame update and
// store access and loads the result register (the store's read data is
// registered alongside it). The store has one write port and one read port,
// used by different beats, so no beat waits on it.
// The store needs no clearing: only entries below the frame length are read.
// Config writes must only happen while no beat is in flight.
module idle_gap_rx_frame_assembler #(
    parameter int  POOL_DEPTH = igrfa_pkg::POOL_DEPTH_DEFAULT,
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [igrfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [igrfa_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [igrfa_pkg::CMD_W-1:0]      s_cmd,
    input  logic [igrfa_pkg::BYTE_W-1:0]     s_rx_byte,
    input  logic [igrfa_pkg::STAMP_W-1:0]    s_stamp,
    input  logic [igrfa_pkg::RIDX_W-1:0]     s_read_index,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_frame_ready,
    output logic [CNT_W-1:0]                 m_frame_length,
    output logic [igrfa_pkg::BYTE_W-1:0]     m_read_data,
    output logic                             m_read_valid,
    output logic                             m_byte_dropped
);
    import igrfa_pkg::*;

    localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    // input register
    logic               in_v_reg, in_v_next;
    cmd_t               in_cmd_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic [STAMP_W-1:0] in_stamp_reg;
    logic [RIDX_W-1:0]  in_ridx_reg;

    // result register
    logic               out_v_reg;
    res_flags_t         out_flags_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic               advance;    // result register free or being drained
    logic               item_en;    // input beat commits this cycle
    logic               s_accept;

    res_flags_t         flags;
    logic [CNT_W-1:0]   count;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0]  rd_data;

    assign advance  = !out_v_reg || m_ready;
    assign item_en  = in_v_reg && advance;
    assign s_ready  = !in_v_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_v_next = in_v_reg;
        if (s_accept) begin
            in_v_next = 1'b1;
        end else if (item_en) begin
            in_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else begin
            in_v_reg <= in_v_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg   <= cmd_t'(s_cmd);
            in_byte_reg  <= s_rx_byte;
            in_stamp_reg <= s_stamp;
            in_ridx_reg  <= s_read_index;
        end
    end

    igrfa_ctrl #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_en    (item_en),
        .cmd        (in_cmd_reg),
        .rx_byte    (in_byte_reg),
        .stamp      (in_stamp_reg),
        .read_index (in_ridx_reg),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .flags      (flags),
        .count      (count)
    );

    // store ports only fire on a committing beat, so the read register holds
    // its value while the result waits
    igrfa_store #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en && item_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en && item_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (advance) begin
            out_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en) begin
            out_flags_reg <= flags;
            out_count_reg <= count;
        end
    end

    assign m_valid        = out_v_reg;
    assign m_frame_ready  = out_flags_reg.frame_ready;
    assign m_frame_length = out_count_reg;
    assign m_read_valid   = out_flags_reg.read_valid;
    assign m_byte_dropped = out_flags_reg.byte_dropped;
    // read data is zero unless this beat was an in-range read
    assign m_read_data    = out_flags_reg.read_valid ? rd_data : '0;

endmodule
